[hw/rtl/ps2_device_link_engine_core_defines.svh]
// Assertion macros shared by the PS/2 device link engine RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PS2_DEVICE_LINK_ENGINE_CORE_DEFINES_SVH
`define PS2_DEVICE_LINK_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PS2DLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ps2dle: implication check failed");

// Next-cycle implication, checked out of reset.
`define PS2DLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ps2dle: next-cycle check failed");

`endif

[hw/rtl/ps2dle_pkg.sv]
// Package for the PS/2 device link engine: item, result and config types
// and the command/response codes. No dependencies.
package ps2dle_pkg;

	localparam int unsigned BitLowW   = 16;
	localparam int unsigned QualW     = 10;
	localparam int unsigned FrameW    = 10;
	localparam int unsigned InDataW   = 16;
	localparam int unsigned OutDataW  = 16;
	localparam int unsigned CfgW      = 16;

	localparam logic [BitLowW-1:0] BitLowReset = 16'd30;
	localparam logic [QualW-1:0]   QualReset   = 10'd100;

	// register indexes on the config port
	localparam logic CFG_BIT_LOW_TICKS   = 1'b0;
	localparam logic CFG_QUALIFY_SAMPLES = 1'b1;

	// host commands and device responses
	localparam logic [7:0] CMD_ECHO     = 8'hEE;
	localparam logic [7:0] CMD_RESET    = 8'hFF;
	localparam logic [7:0] CMD_GET_ID   = 8'hF2;
	localparam logic [7:0] RSP_ECHO     = 8'hEE;
	localparam logic [7:0] RSP_BAT_OK   = 8'hAA;
	localparam logic [7:0] RSP_ACK      = 8'hFA;
	localparam logic [7:0] RSP_ID_BYTE  = 8'hAB;

	typedef struct packed {
		logic [BitLowW-1:0] bit_low_ticks;
		logic [QualW-1:0]   qualify_samples;
	} ps2dle_cfg_t;

	typedef struct packed {
		logic [7:0] send_byte;
		logic       send_request;
		logic       dat_in;
		logic       clk_in;
	} ps2dle_item_t;

	typedef struct packed {
		logic [FrameW-1:0] rx_frame;
		logic              rx_valid;
		logic              send_taken;
		logic              busy_res;
		logic              dat_drive_low;
		logic              clk_drive_low;
	} ps2dle_res_t;

endpackage

[hw/rtl/ps2dle_engine.sv]
// Link engine state and per-tick next-state logic for the PS/2 device link.
// Depends on ps2dle_pkg and the assertion macro header.
`include "ps2_device_link_engine_core_defines.svh"

module ps2dle_engine import ps2dle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  ps2dle_item_t item,
	input  ps2dle_cfg_t  cfg,
	output ps2dle_res_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_QLOW   = 4'd1,
		PH_QHIGH  = 4'd2,
		PH_TXPRE  = 4'd3,
		PH_TXLOW  = 4'd4,
		PH_TXPOST = 4'd5,
		PH_RXPRE  = 4'd6,
		PH_RXLOW  = 4'd7,
		PH_RXPOST = 4'd8,
		PH_GAP    = 4'd9
	} phase_t;

	localparam logic [3:0] FrameBits  = 4'd11;
	localparam logic [3:0] RxDataBits = 4'd10;

	phase_t              phase_q, phase_d;
	logic [BitLowW-1:0]  timer_q, timer_d;
	logic [3:0]          bit_idx_q, bit_idx_d;
	logic [FrameW-1:0]   shift_q, shift_d;
	logic                parity_q, parity_d;
	logic [7:0]          tx_byte_q, tx_byte_d;
	logic                fup_q, fup_d;
	logic [QualW-1:0]    qcnt_q, qcnt_d;

	logic [BitLowW-1:0]  full_len, half_raw, half_len, timer_inc;
	logic                done_full, done_half;
	logic [QualW-1:0]    q_len, qcnt_inc;
	logic                taken, rxv;
	logic [7:0]          resp;
	logic                tx_bit;
	logic [3:0]          bit_idx_inc;

	assign half_raw  = cfg.bit_low_ticks >> 1;
	assign full_len  = (cfg.bit_low_ticks == '0) ? BitLowW'(1) : cfg.bit_low_ticks;
	assign half_len  = (half_raw == '0) ? BitLowW'(1) : half_raw;
	assign timer_inc = timer_q + BitLowW'(1);
	assign done_full = timer_inc >= full_len;
	assign done_half = timer_inc >= half_len;
	assign q_len     = (cfg.qualify_samples == '0) ? QualW'(1) : cfg.qualify_samples;
	assign qcnt_inc  = qcnt_q + QualW'(1);
	assign bit_idx_inc = bit_idx_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		parity_d  = parity_q;
		tx_byte_d = tx_byte_q;
		fup_d     = fup_q;
		qcnt_d    = qcnt_q;
		taken     = 1'b0;
		rxv       = 1'b0;
		resp      = RSP_ACK;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.send_request) begin
					taken     = 1'b1;
					fup_d     = 1'b0;
					tx_byte_d = item.send_byte;
					parity_d  = ~^item.send_byte;
					bit_idx_d = 4'd0;
					timer_d   = '0;
					phase_d   = PH_TXPRE;
				end else if (!item.clk_in) begin
					timer_d = '0;
					if (q_len == QualW'(1)) begin
						phase_d = PH_QHIGH;
						qcnt_d  = '0;
					end else begin
						phase_d = PH_QLOW;
						qcnt_d  = QualW'(1);
					end
				end
			end
			PH_QLOW: begin
				if (item.clk_in) begin
					phase_d = PH_IDLE;
					qcnt_d  = '0;
				end else if (qcnt_inc >= q_len) begin
					phase_d = PH_QHIGH;
					qcnt_d  = '0;
				end else begin
					qcnt_d = qcnt_inc;
				end
			end
			PH_QHIGH: begin
				if (!item.clk_in) begin
					qcnt_d = '0;
				end else if (qcnt_inc >= q_len) begin
					qcnt_d    = '0;
					phase_d   = PH_RXPRE;
					bit_idx_d = 4'd0;
					timer_d   = '0;
					shift_d   = '0;
				end else begin
					qcnt_d = qcnt_inc;
				end
			end
			PH_TXPRE: begin
				timer_d = done_half ? '0 : timer_inc;
				if (done_half) phase_d = PH_TXLOW;
			end
			PH_TXLOW: begin
				timer_d = done_full ? '0 : timer_inc;
				if (done_full) phase_d = PH_TXPOST;
			end
			PH_TXPOST: begin
				timer_d = done_half ? '0 : timer_inc;
				if (done_half) begin
					if (bit_idx_inc >= FrameBits) begin
						bit_idx_d = 4'd0;
						phase_d   = PH_GAP;
					end else begin
						bit_idx_d = bit_idx_inc;
						phase_d   = PH_TXPRE;
					end
				end
			end
			PH_RXPRE: begin
				timer_d = done_half ? '0 : timer_inc;
				if (done_half) phase_d = PH_RXLOW;
			end
			PH_RXLOW: begin
				timer_d = done_full ? '0 : timer_inc;
				if (done_full) begin
					// data is sampled as the clock-low period ends
					if (bit_idx_q < RxDataBits)
						shift_d[bit_idx_q] = shift_q[bit_idx_q] | item.dat_in;
					phase_d = PH_RXPOST;
				end
			end
			PH_RXPOST: begin
				timer_d = done_half ? '0 : timer_inc;
				if (done_half) begin
					if (bit_idx_inc >= FrameBits) begin
						rxv = 1'b1;
						priority if (shift_q[7:0] == CMD_ECHO)  resp = RSP_ECHO;
						else if (shift_q[7:0] == CMD_RESET)     resp = RSP_BAT_OK;
						else                                     resp = RSP_ACK;
						fup_d     = (shift_q[7:0] == CMD_GET_ID);
						tx_byte_d = resp;
						parity_d  = ~^resp;
						bit_idx_d = 4'd0;
						timer_d   = '0;
						phase_d   = PH_TXPRE;
					end else begin
						bit_idx_d = bit_idx_inc;
						phase_d   = PH_RXPRE;
					end
				end
			end
			PH_GAP: begin
				timer_d = done_full ? '0 : timer_inc;
				if (done_full) begin
					// bit_index marks the extra gap before the ID byte
					priority if (fup_q && bit_idx_q == 4'd0) begin
						bit_idx_d = 4'd1;
					end else if (fup_q) begin
						fup_d     = 1'b0;
						tx_byte_d = RSP_ID_BYTE;
						parity_d  = ~^RSP_ID_BYTE;
						bit_idx_d = 4'd0;
						timer_d   = '0;
						phase_d   = PH_TXPRE;
					end else begin
						bit_idx_d = 4'd0;
						phase_d   = PH_IDLE;
					end
				end
			end
			default: begin
				phase_d   = PH_IDLE;
				timer_d   = '0;
				bit_idx_d = 4'd0;
				qcnt_d    = '0;
			end
		endcase
	end

	// drive levels follow the updated state
	always_comb begin
		priority if (bit_idx_d == 4'd0) tx_bit = 1'b0;
		else if (bit_idx_d <= 4'd8)     tx_bit = tx_byte_d[3'(bit_idx_d - 4'd1)];
		else if (bit_idx_d == 4'd9)     tx_bit = parity_d;
		else                            tx_bit = 1'b1;
	end

	always_comb begin
		res               = '0;
		res.clk_drive_low = (phase_d == PH_TXLOW) || (phase_d == PH_RXLOW);
		if (phase_d == PH_TXPRE || phase_d == PH_TXLOW || phase_d == PH_TXPOST)
			res.dat_drive_low = ~tx_bit;
		else if (phase_d == PH_RXPRE || phase_d == PH_RXLOW || phase_d == PH_RXPOST)
			res.dat_drive_low = (bit_idx_d >= RxDataBits);
		res.busy_res   = (phase_d != PH_IDLE);
		res.send_taken = taken;
		res.rx_valid   = rxv;
		res.rx_frame   = rxv ? shift_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			bit_idx_q <= 4'd0;
			shift_q   <= '0;
			parity_q  <= 1'b1;
			tx_byte_q <= 8'd0;
			fup_q     <= 1'b0;
			qcnt_q    <= '0;
		end else if (adv) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			parity_q  <= parity_d;
			tx_byte_q <= tx_byte_d;
			fup_q     <= fup_d;
			qcnt_q    <= qcnt_d;
		end
	end

	`PS2DLE_ASSERT_IMP(a_rx_starts_reply, clk, arst_n, adv && res.rx_valid, phase_d == PH_TXPRE)
	`PS2DLE_ASSERT_IMP(a_take_only_idle, clk, arst_n, res.send_taken, phase_q == PH_IDLE)
	`PS2DLE_ASSERT_NXT(a_hold_when_stalled, clk, arst_n, !adv, $stable(phase_q) && $stable(timer_q))
	`PS2DLE_ASSERT_IMP(a_bit_idx_range, clk, arst_n, 1'b1, bit_idx_q <= RxDataBits)

endmodule

[hw/rtl/ps2dle_out_stage.sv]
// Result register of the PS/2 device link engine, master side of the stream.
// Depends on ps2dle_pkg.
module ps2dle_out_stage import ps2dle_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ps2dle_res_t         res,
	output logic                ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata
);

	logic        valid_q;
	ps2dle_res_t res_q;

	assign ready    = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = OutDataW'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) res_q <= res;
	end

endmodule

[hw/rtl/ps2_device_link_engine_core.sv]
// PS/2 device link engine, device side of the two-wire link.
// Each input item on s_axis is one time tick: the sampled clock and data
// lines plus an optional send request. Each item yields exactly one result
// item on m_axis with the clock/data pull-down levels after that tick,
// busy, send_taken and, on the tick a host frame completes, rx_valid and
// the ten received bits. Idle, a send request starts an 11-bit frame;
// a qualified host request (clock low, then high) starts reception,
// followed by the reply (and the ID byte after a get-ID command).
// An accepted item is held in the input register; its result is offered
// from the result register. Throughput: one item per cycle while the result
// register can take it, set by the combinational state update between them.
// When m_tready is low and a result waits, the result register holds, and
// s_tready drops while the input register is full, until the result moves.
// Reset (arst_n low) returns to idle, clears both valid flags and loads the
// default timing (30 ticks per bit low, 100 qualify samples).
// cfg_we/cfg_index/cfg_wdata write a timing register.
// Depends on ps2dle_pkg, ps2dle_engine and ps2dle_out_stage.
module ps2_device_link_engine_core import ps2dle_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [0] clk_in, [1] dat_in, [2] send_request, [10:3] send_byte, rest zero
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] clk_drive_low, [1] dat_drive_low, [2] busy_res, [3] send_taken,
	// [4] rx_valid, [14:5] rx_frame, [15] zero
	output logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CfgW-1:0]     cfg_wdata
);

	logic         in_valid_s1;
	ps2dle_item_t in_item_s1;
	ps2dle_cfg_t  cfg_q;
	ps2dle_res_t  res;
	logic         out_ready;
	logic         adv;

	assign adv      = in_valid_s1 && out_ready;
	assign s_tready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) in_item_s1 <= ps2dle_item_t'(s_tdata[$bits(ps2dle_item_t)-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_low_ticks   <= BitLowReset;
			cfg_q.qualify_samples <= QualReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIT_LOW_TICKS:   cfg_q.bit_low_ticks   <= cfg_wdata[BitLowW-1:0];
				CFG_QUALIFY_SAMPLES: cfg_q.qualify_samples <= cfg_wdata[QualW-1:0];
				default: ;
			endcase
		end
	end

	ps2dle_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (in_item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	ps2dle_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[bench/ps2_link_checker.sv]
// Checker for the PS/2 device link engine: watches the item, result and config ports,
// predicts every result from its own copy of the engine and compares field by field.
// Depends on ps2dle_pkg only.
module ps2_link_checker import ps2dle_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CfgW-1:0]     cfg_wdata,
	output int unsigned         mismatches,
	output int unsigned         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		LNK_IDLE, LNK_QLOW, LNK_QHIGH, LNK_TXPRE, LNK_TXLOW, LNK_TXPOST,
		LNK_RXPRE, LNK_RXLOW, LNK_RXPOST, LNK_GAP
	} link_phase_e;

	localparam int unsigned FrameBits = 11;
	localparam int unsigned RxBits    = 10;

	logic [BitLowW-1:0] low_ticks;
	logic [QualW-1:0]   qual_len;

	link_phase_e  phase;
	logic [15:0]  tick_ctr;
	logic [3:0]   bit_pos;
	logic [9:0]   rx_shift;
	logic         tx_par;
	logic [7:0]   tx_data;
	logic         id_pending;
	logic [9:0]   qual_ctr;

	ps2dle_res_t  line_results_q[$];
	int unsigned  results_seen;

	// a zero-length period still lasts one tick
	function automatic bit period_done(input logic [15:0] len);
		logic [15:0] n;
		n = (len == 16'd0) ? 16'd1 : len;
		tick_ctr = tick_ctr + 16'd1;
		if (tick_ctr >= n) begin
			tick_ctr = 16'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void start_frame(input logic [7:0] b);
		tx_data  = b;
		tx_par   = ~^b;
		bit_pos  = 4'd0;
		tick_ctr = 16'd0;
		phase    = LNK_TXPRE;
	endfunction

	// start, eight data bits LSB first, odd parity, stop
	function automatic logic frame_bit();
		if (bit_pos == 4'd0) return 1'b0;
		if (bit_pos <= 4'd8) return tx_data[bit_pos - 4'd1];
		if (bit_pos == 4'd9) return tx_par;
		return 1'b1;
	endfunction

	function automatic ps2dle_res_t step_link(input ps2dle_item_t it);
		logic [15:0]      half;
		logic [15:0]      full;
		logic [QualW-1:0] qn;
		logic [7:0]       cmd;
		ps2dle_res_t      r;
		full = low_ticks;
		half = low_ticks >> 1;
		qn   = (qual_len == '0) ? QualW'(1) : qual_len;
		r    = '0;
		case (phase)
			LNK_QLOW: begin
				if (it.clk_in) begin
					phase    = LNK_IDLE;
					qual_ctr = '0;
				end else begin
					qual_ctr = qual_ctr + 10'd1;
					if (qual_ctr >= qn) begin
						phase    = LNK_QHIGH;
						qual_ctr = '0;
					end
				end
			end
			LNK_QHIGH: begin
				// a low sample restarts the high count
				if (!it.clk_in) begin
					qual_ctr = '0;
				end else begin
					qual_ctr = qual_ctr + 10'd1;
					if (qual_ctr >= qn) begin
						qual_ctr = '0;
						phase    = LNK_RXPRE;
						bit_pos  = 4'd0;
						tick_ctr = 16'd0;
						rx_shift = '0;
					end
				end
			end
			LNK_TXPRE: if (period_done(half)) phase = LNK_TXLOW;
			LNK_TXLOW: if (period_done(full)) phase = LNK_TXPOST;
			LNK_TXPOST: begin
				if (period_done(half)) begin
					bit_pos = bit_pos + 4'd1;
					if (bit_pos >= FrameBits) begin
						bit_pos = 4'd0;
						phase   = LNK_GAP;
					end else begin
						phase = LNK_TXPRE;
					end
				end
			end
			LNK_RXPRE: if (period_done(half)) phase = LNK_RXLOW;
			LNK_RXLOW: begin
				// data is taken on the tick that ends the low period
				if (period_done(full)) begin
					if (bit_pos < RxBits) rx_shift = rx_shift | (10'(it.dat_in) << bit_pos);
					phase = LNK_RXPOST;
				end
			end
			LNK_RXPOST: begin
				if (period_done(half)) begin
					bit_pos = bit_pos + 4'd1;
					if (bit_pos >= FrameBits) begin
						cmd        = rx_shift[7:0];
						r.rx_valid = 1'b1;
						r.rx_frame = rx_shift;
						id_pending = (cmd == CMD_GET_ID);
						if (cmd == CMD_ECHO) start_frame(RSP_ECHO);
						else if (cmd == CMD_RESET) start_frame(RSP_BAT_OK);
						else start_frame(RSP_ACK);
					end else begin
						phase = LNK_RXPRE;
					end
				end
			end
			LNK_GAP: begin
				// after the get-ID answer a second gap, then the ID byte
				if (period_done(full)) begin
					if (id_pending && bit_pos == 4'd0) begin
						bit_pos = 4'd1;
					end else if (id_pending) begin
						id_pending = 1'b0;
						start_frame(RSP_ID_BYTE);
					end else begin
						bit_pos = 4'd0;
						phase   = LNK_IDLE;
					end
				end
			end
			LNK_IDLE: begin
				// a send request wins over a low clock
				if (it.send_request) begin
					r.send_taken = 1'b1;
					id_pending   = 1'b0;
					start_frame(it.send_byte);
				end else if (!it.clk_in) begin
					qual_ctr = 10'd1;
					tick_ctr = 16'd0;
					if (qual_ctr >= qn) begin
						phase    = LNK_QHIGH;
						qual_ctr = '0;
					end else begin
						phase = LNK_QLOW;
					end
				end
			end
			default: begin
				phase    = LNK_IDLE;
				tick_ctr = 16'd0;
				bit_pos  = 4'd0;
				qual_ctr = '0;
			end
		endcase

		if (phase inside {LNK_TXPRE, LNK_TXLOW, LNK_TXPOST})
			r.dat_drive_low = ~frame_bit();
		else if (phase inside {LNK_RXPRE, LNK_RXLOW, LNK_RXPOST})
			r.dat_drive_low = (bit_pos >= RxBits);
		r.clk_drive_low = (phase == LNK_TXLOW || phase == LNK_RXLOW);
		r.busy_res      = (phase != LNK_IDLE);
		return r;
	endfunction

	task automatic log_failure(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ps2dle_item_t it;
		ps2dle_res_t  want;
		ps2dle_res_t  got;
		if (!arst_n) begin
			low_ticks    = BitLowReset;
			qual_len     = QualReset;
			phase        = LNK_IDLE;
			tick_ctr     = '0;
			bit_pos      = '0;
			rx_shift     = '0;
			tx_par       = 1'b1;
			tx_data      = '0;
			id_pending   = 1'b0;
			qual_ctr     = '0;
			results_seen = 0;
			mismatches   = 0;
			line_results_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BIT_LOW_TICKS:   low_ticks = cfg_wdata[BitLowW-1:0];
					CFG_QUALIFY_SAMPLES: qual_len  = cfg_wdata[QualW-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				it = s_tdata[$bits(ps2dle_item_t)-1:0];
				line_results_q.push_back(step_link(it));
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(ps2dle_res_t)-1:0];
				if (line_results_q.size() == 0) begin
					log_failure($sformatf("result %0d arrived with nothing expected (%h)",
						results_seen, got));
				end else begin
					want = line_results_q.pop_front();
					if (got.clk_drive_low !== want.clk_drive_low ||
						got.dat_drive_low !== want.dat_drive_low ||
						got.busy_res !== want.busy_res ||
						got.send_taken !== want.send_taken ||
						got.rx_valid !== want.rx_valid ||
						got.rx_frame !== want.rx_frame)
						log_failure($sformatf({"result %0d: clk/dat/busy/taken/rxv/frame ",
							"expected %b%b%b%b%b %03h, got %b%b%b%b%b %03h"}, results_seen,
							want.clk_drive_low, want.dat_drive_low, want.busy_res,
							want.send_taken, want.rx_valid, want.rx_frame,
							got.clk_drive_low, got.dat_drive_low, got.busy_res,
							got.send_taken, got.rx_valid, got.rx_frame));
				end
				results_seen++;
			end
		end
		outstanding = line_results_q.size();
	end

endmodule

[bench/testbench.sv]
// Top of the PS/2 device link engine bench: clock, reset, line-tick stimulus with
// host frames, send requests, aborts and noise, register writes and the verdict.
// Depends on ps2dle_pkg, ps2_device_link_engine_core and ps2_link_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ps2dle_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we;
	logic                cfg_index;
	logic [CfgW-1:0]     cfg_wdata;

	int unsigned mismatches;
	int unsigned outstanding;

	// timing the engine is running with, kept to shape the line waveforms
	logic [BitLowW-1:0] blt_now;
	logic [QualW-1:0]   qual_now;
	int unsigned        live_items = 0;
	int unsigned        taken_results = 0;
	int unsigned        hold_left = 0;
	bit                 hold_done = 1'b0;

	ps2_device_link_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ps2_link_checker link_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) taken_results <= taken_results + 1;
	end

	// result side: random stalls, one long hold-off, and a stretch always ready
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && taken_results >= 300) begin
			hold_done <= 1'b1;
			hold_left <= 150;
			m_tready  <= 1'b0;
		end else if (taken_results >= 650 && taken_results < 850) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 38);
		end
	end

	function automatic int unsigned half_ticks();
		return ((blt_now >> 1) == 0) ? 1 : int'(blt_now >> 1);
	endfunction

	function automatic int unsigned full_ticks();
		return (blt_now == 0) ? 1 : int'(blt_now);
	endfunction

	function automatic int unsigned qual_ticks();
		return (qual_now == 0) ? 1 : int'(qual_now);
	endfunction

	function automatic int unsigned bit_ticks();
		return 2 * half_ticks() + full_ticks();
	endfunction

	// one frame on the wire plus the gap after it
	function automatic int unsigned frame_ticks();
		return 11 * bit_ticks() + full_ticks();
	endfunction

	task automatic push_tick(input logic c, input logic d, input logic rq,
		input logic [7:0] b);
		ps2dle_item_t       it;
		logic [InDataW-1:0] word;
		it.clk_in       = c;
		it.dat_in       = d;
		it.send_request = rq;
		it.send_byte    = b;
		word            = '0;
		word[$bits(ps2dle_item_t)-1:0] = it;
		@(negedge clk);
		if (!(live_items >= 500 && live_items < 700)) begin
			while ($urandom_range(99) < 38) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		live_items++;
	endtask

	// ticks while the engine is busy; a request here must be ignored
	task automatic pad_ticks(input int unsigned n, input bit req_noise);
		repeat (n) push_tick(1'b1, $urandom, req_noise ? $urandom : 1'b0, $urandom);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BIT_LOW_TICKS) blt_now = val;
		else qual_now = val[QualW-1:0];
	endtask

	// host request: clock low, clock high, then ten bits plus the ack slot
	task automatic host_frame(input logic [9:0] bits, input bit glitch);
		int unsigned q;
		int unsigned p;
		logic        d;
		q = qual_ticks();
		p = bit_ticks();
		repeat (q + $urandom_range(2)) push_tick(1'b0, $urandom, 1'b0, $urandom);
		if (glitch && q > 1) begin
			repeat ($urandom_range(q - 1, 1)) push_tick(1'b1, $urandom, 1'b0, $urandom);
			push_tick(1'b0, $urandom, 1'b0, $urandom);
		end
		repeat (q) push_tick(1'b1, $urandom, 1'b0, $urandom);
		for (int i = 0; i < 11; i++) begin
			d = (i < 10) ? bits[i] : $urandom;
			for (int t = 0; t < p; t++)
				push_tick($urandom, d, $urandom, $urandom);
		end
		pad_ticks(frame_ticks(), 1'b1);
		if (bits[7:0] == CMD_GET_ID) pad_ticks(full_ticks() + frame_ticks(), 1'b1);
		pad_ticks(3, 1'b0);
	endtask

	task automatic send_byte_frame(input logic [7:0] b, input logic c);
		push_tick(c, $urandom, 1'b1, b);
		pad_ticks(frame_ticks(), 1'b1);
		pad_ticks(3, 1'b0);
	endtask

	// clock released before the low count completes
	task automatic aborted_request();
		repeat ($urandom_range(qual_ticks() - 1, 1))
			push_tick(1'b0, $urandom, 1'b0, $urandom);
		push_tick(1'b1, $urandom, 1'b0, $urandom);
		pad_ticks(2, 1'b0);
	endtask

	task automatic line_noise();
		repeat ($urandom_range(16, 4))
			push_tick($urandom, $urandom, $urandom_range(9) == 0, $urandom);
		// worst case the noise started a host frame ending in the ID byte
		pad_ticks(qual_ticks() + 11 * bit_ticks() + 2 * frame_ticks() + full_ticks() + 3, 1'b0);
	endtask

	initial begin
		logic [7:0] cmd;
		logic [1:0] tail;
		int unsigned pick;
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_BIT_LOW_TICKS;
		cfg_wdata = '0;
		blt_now   = BitLowReset;
		qual_now  = QualReset;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset timing, send colliding with a low clock, then shortened mid-frame
		push_tick(1'b0, $urandom, 1'b1, 8'h00);
		pad_ticks(20, 1'b1);
		drain_results();
		write_reg(CFG_BIT_LOW_TICKS, 16'd2);
		pad_ticks(frame_ticks() + 3, 1'b0);
		drain_results();
		write_reg(CFG_QUALIFY_SAMPLES, 16'd1);
		host_frame({2'b01, CMD_ECHO}, 1'b0);
		host_frame({2'b11, CMD_RESET}, 1'b0);
		host_frame({2'b00, CMD_GET_ID}, 1'b0);
		host_frame(10'h000, 1'b0);
		host_frame(10'h3FF, 1'b0);
		drain_results();
		write_reg(CFG_QUALIFY_SAMPLES, 16'd0);
		host_frame(10'h2AA, 1'b0);
		send_byte_frame(8'hFF, 1'b1);
		drain_results();
		write_reg(CFG_QUALIFY_SAMPLES, 16'd3);
		aborted_request();
		host_frame(10'h155, 1'b1);
		drain_results();
		write_reg(CFG_BIT_LOW_TICKS, 16'd0);
		send_byte_frame(8'hA5, 1'b1);
		host_frame({2'b10, CMD_GET_ID}, 1'b0);
		drain_results();
		write_reg(CFG_BIT_LOW_TICKS, 16'd1);
		send_byte_frame(8'h5A, 1'b0);
		line_noise();

		// longest bit period, cut short once the frame has started
		drain_results();
		write_reg(CFG_BIT_LOW_TICKS, 16'hFFFF);
		push_tick(1'b1, 1'b0, 1'b1, 8'h3C);
		pad_ticks(20, 1'b1);
		drain_results();
		write_reg(CFG_BIT_LOW_TICKS, 16'd3);
		pad_ticks(frame_ticks() + 3, 1'b0);

		// longest qualify, shortened while the clock is held low
		drain_results();
		write_reg(CFG_QUALIFY_SAMPLES, 16'd1023);
		repeat (20) push_tick(1'b0, $urandom, 1'b0, $urandom);
		drain_results();
		write_reg(CFG_QUALIFY_SAMPLES, 16'd2);
		host_frame({2'b01, CMD_RESET}, 1'b0);

		live_items = 0;
		while (live_items < 400) begin
			if ($urandom_range(5) == 0) begin
				drain_results();
				write_reg(CFG_BIT_LOW_TICKS, ($urandom_range(99) < 85) ?
					$urandom_range(6) : $urandom_range(16, 7));
				write_reg(CFG_QUALIFY_SAMPLES, ($urandom_range(99) < 85) ?
					$urandom_range(5) : $urandom_range(12, 6));
			end
			pick = $urandom_range(99);
			if (pick < 45) begin
				case ($urandom_range(3))
					0: cmd = CMD_ECHO;
					1: cmd = CMD_RESET;
					2: cmd = CMD_GET_ID;
					default: cmd = $urandom;
				endcase
				tail = $urandom;
				host_frame({tail, cmd}, $urandom_range(4) == 0);
			end else if (pick < 70) begin
				send_byte_frame($urandom, $urandom);
			end else if (pick < 85 && qual_ticks() > 1) begin
				aborted_request();
			end else begin
				line_noise();
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ps2dle_pkg.sv
hw/rtl/ps2dle_engine.sv
hw/rtl/ps2dle_out_stage.sv
hw/rtl/ps2_device_link_engine_core.sv
bench/ps2_link_checker.sv
bench/testbench.sv
